// ===== design/vector3_arithmetic_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit assertion macros
// Shared property wrappers for the checker; clock and reset come from the scope.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define VAU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit package
// Widths, opcodes, status codes, result bundle and shared arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

   localparam int DW = 32;            // data word, Q16.16
   localparam int FB = 16;            // fraction bits
   localparam int KW = 4;             // opcode width
   localparam int AW = 19;            // angle width
   localparam int PW = 2 * DW;        // full product
   localparam int WW = 2 * DW + 2;    // sum of three products
   localparam int MW = DW;            // magnitude width
   localparam int QW = FB + 1;        // normalize quotient magnitude
   localparam int CW = FB + 2;        // sine / cosine width

   localparam int CORDIC_STEPS = 17;
   localparam int CORDIC_FRAC  = 30;
   localparam int XW = 34;            // CORDIC x / y
   localparam int ZW = 19;            // CORDIC residual angle
   localparam logic signed [XW-1:0] CORDIC_GAIN_INV = XW'(652032874);
   localparam logic signed [ZW:0]   PI_Q16          = (ZW + 1)'(205887);
   localparam logic signed [ZW:0]   HALF_PI_Q16     = (ZW + 1)'(102944);

   localparam int SQRT_STEPS = MW;
   localparam int PIPE_DEPTH = 53;

   localparam logic signed [WW-1:0] SAT_MAX = (WW'(1) <<< (DW - 1)) - WW'(1);
   localparam logic signed [WW-1:0] SAT_MIN = -SAT_MAX - WW'(1);

   typedef enum logic [KW-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_DOT   = 4'd2,
      OP_CROSS = 4'd3,
      OP_MAG   = 4'd4,
      OP_NORM  = 4'd5,
      OP_ROTX  = 4'd6,
      OP_ROTY  = 4'd7,
      OP_ROTZ  = 4'd8,
      OP_DIST  = 4'd9,
      OP_SCALE = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef logic [2:0][DW-1:0] vec_type;

   typedef struct packed {
      logic                 sat;
      logic signed [DW-1:0] val;
   } sat_type;

   typedef struct packed {
      op_type               kind;
      logic signed [DW-1:0] rx;
      logic signed [DW-1:0] ry;
      logic signed [DW-1:0] rz;
      logic signed [DW-1:0] sc;
      status_type           st;
   } res_type;

   function automatic sat_type sat_w(input logic signed [WW-1:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r.sat = 1'b1;
         r.val = SAT_MAX[DW-1:0];
      end else if (v < SAT_MIN) begin
         r.sat = 1'b1;
         r.val = SAT_MIN[DW-1:0];
      end else begin
         r.sat = 1'b0;
         r.val = v[DW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0:       r = ZW'(51472);
         1:       r = ZW'(30386);
         2:       r = ZW'(16055);
         3:       r = ZW'(8150);
         4:       r = ZW'(4091);
         5:       r = ZW'(2047);
         6:       r = ZW'(1024);
         7:       r = ZW'(512);
         8:       r = ZW'(256);
         9:       r = ZW'(128);
         10:      r = ZW'(64);
         11:      r = ZW'(32);
         12:      r = ZW'(16);
         13:      r = ZW'(8);
         14:      r = ZW'(4);
         15:      r = ZW'(2);
         16:      r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/vau_delay.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit delay line
// Enable-gated shift line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/vau_cordic.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit CORDIC
// One rotation step per stage, then a clamp and sign stage for sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_cordic import vau_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [ZW-1:0] ang_z,
   input  logic                 ang_neg,
   output logic signed [CW-1:0] cos_out,
   output logic signed [CW-1:0] sin_out
);

   localparam int TW = XW - (CORDIC_FRAC - FB);
   localparam logic signed [TW-1:0] ONE = TW'(1) <<< FB;

   logic signed [XW-1:0] x_ff [CORDIC_STEPS];
   logic signed [XW-1:0] y_ff [CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff [CORDIC_STEPS];
   logic                 neg_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XW-1:0] xp, yp, x_in, y_in;
      logic signed [ZW-1:0] zp, z_in;
      logic                 np;

      if (i == 0) begin : g_first
         assign xp = CORDIC_GAIN_INV;
         assign yp = '0;
         assign zp = ang_z;
         assign np = ang_neg;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign np = neg_ff[i-1];
      end

      always_comb begin
         if (zp >= 0) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - atan_q16(i);
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + atan_q16(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            neg_ff[i] <= np;
         end
      end
   end

   logic signed [TW-1:0] xs, ys, xc, yc, xf, yf;
   logic signed [CW-1:0] cos_ff, sin_ff, cos_in, sin_in;

   // drop the extra fraction bits, clamp to +-1, undo the half-turn fold
   always_comb begin
      xs = x_ff[CORDIC_STEPS-1][XW-1:CORDIC_FRAC-FB];
      ys = y_ff[CORDIC_STEPS-1][XW-1:CORDIC_FRAC-FB];
      xc = (xs > ONE) ? ONE : ((xs < -ONE) ? -ONE : xs);
      yc = (ys > ONE) ? ONE : ((ys < -ONE) ? -ONE : ys);
      xf = neg_ff[CORDIC_STEPS-1] ? -xc : xc;
      yf = neg_ff[CORDIC_STEPS-1] ? -yc : yc;
      cos_in = xf[CW-1:0];
      sin_in = yf[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

// ===== design/vau_sqrt.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_sqrt import vau_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [PW-1:0] sq_in,
   output logic [MW-1:0] root_out
);

   logic [PW-1:0] n_ff [SQRT_STEPS];
   logic [PW-1:0] r_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2 * k);
      logic [PW-1:0] np, rp, trial, n_in, r_in;

      if (k == 0) begin : g_first
         assign np = sq_in;
         assign rp = '0;
      end else begin : g_next
         assign np = n_ff[k-1];
         assign rp = r_ff[k-1];
      end

      always_comb begin
         trial = rp + BIT;
         if (np >= trial) begin
            n_in = np - trial;
            r_in = (rp >> 1) + BIT;
         end else begin
            n_in = np;
            r_in = rp >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root_out = r_ff[SQRT_STEPS-1][MW-1:0];

endmodule

`default_nettype wire

// ===== design/vau_div.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit normalize divider
// Pipelined restoring division of comp * 2^FB by the magnitude, truncated to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_div import vau_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] num_in,
   input  logic [MW-1:0]        den_in,
   output logic signed [QW:0]   quo_out
);

   localparam int NW = DW + FB;

   logic [NW-1:0] rem_ff [QW];
   logic [MW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic          neg_ff [QW];

   logic [DW-1:0] mag;

   // the component never exceeds the magnitude, so the quotient fits QW bits
   assign mag = num_in[DW-1] ? DW'(-num_in) : DW'(num_in);

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int J = QW - 1 - k;
      logic [NW-1:0] remp, sh, rem_in;
      logic [MW-1:0] denp;
      logic [QW-1:0] quop, quo_in;
      logic          np;

      if (k == 0) begin : g_first
         assign remp = {mag, {FB{1'b0}}};
         assign denp = den_in;
         assign quop = '0;
         assign np   = num_in[DW-1];
      end else begin : g_next
         assign remp = rem_ff[k-1];
         assign denp = den_ff[k-1];
         assign quop = quo_ff[k-1];
         assign np   = neg_ff[k-1];
      end

      always_comb begin
         sh = NW'(denp) << J;
         if (remp >= sh) begin
            rem_in = remp - sh;
            quo_in = quop | (QW'(1) << J);
         end else begin
            rem_in = remp;
            quo_in = quop;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= denp;
            quo_ff[k] <= quo_in;
            neg_ff[k] <= np;
         end
      end
   end

   logic signed [QW:0] qpos;

   assign qpos    = $signed({1'b0, quo_ff[QW-1]});
   assign quo_out = neg_ff[QW-1] ? -qpos : qpos;

endmodule

`default_nettype wire

// ===== design/vector3_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit core
// Add, sub, dot, cross, magnitude, normalize, rotate, distance and scale in Q16.16.
// ----------------------------------------------------------------------------
// Fully pipelined: one request beat is taken every cycle and each one gives one
// response beat in order at the pipeline end. The depth is set by the 32-stage
// square root followed by the 17-stage normalize divider; every operation goes
// through the same depth. The whole pipeline advances together, so it only
// holds while a finished response beat waits on rsp_ready, and req_ready is low
// exactly then. Overflow saturates with status 1; normalizing a zero vector
// gives zeros with status 2; unused opcodes give zeros with status 0.
`default_nettype none

module vector3_arithmetic_unit_core import vau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KW-1:0]        req_kind,
   input  logic signed [DW-1:0] req_ax,
   input  logic signed [DW-1:0] req_ay,
   input  logic signed [DW-1:0] req_az,
   input  logic signed [DW-1:0] req_bx,
   input  logic signed [DW-1:0] req_by,
   input  logic signed [DW-1:0] req_bz,
   input  logic signed [AW-1:0] req_angle,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [DW-1:0] rsp_rx,
   output logic signed [DW-1:0] rsp_ry,
   output logic signed [DW-1:0] rsp_rz,
   output logic signed [DW-1:0] rsp_scalar,
   output logic [1:0]           rsp_status
);

   localparam int RPW = CW + DW;

   logic adv;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // ---------------- stage 0: capture ----------------
   op_type               kind0_ff;
   vec_type              a0_ff, b0_ff;
   logic signed [AW-1:0] ang0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kind0_ff <= op_type'(req_kind);
         a0_ff    <= {req_az, req_ay, req_ax};
         b0_ff    <= {req_bz, req_by, req_bx};
         ang0_ff  <= req_angle;
      end
   end

   // ---------------- stage 1: add/sub, operand select, angle fold ----------------
   sat_type              sum_s [3];
   sat_type              dif_s [3];
   vec_type              d1, as1_in;
   logic [5:0][DW-1:0]   opa_in, opb_in;
   logic                 f1_in;
   logic signed [ZW:0]   aext;
   logic signed [ZW-1:0] z1_in;
   logic                 neg1_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_s[i] = sat_w(WW'($signed(a0_ff[i])) + WW'($signed(b0_ff[i])));
         dif_s[i] = sat_w(WW'($signed(a0_ff[i])) - WW'($signed(b0_ff[i])));
         d1[i]     = dif_s[i].val;
         as1_in[i] = (kind0_ff == OP_SUB) ? dif_s[i].val : sum_s[i].val;
      end
      f1_in = ((kind0_ff == OP_ADD) && (sum_s[0].sat || sum_s[1].sat || sum_s[2].sat)) ||
              (((kind0_ff == OP_SUB) || (kind0_ff == OP_DIST)) &&
               (dif_s[0].sat || dif_s[1].sat || dif_s[2].sat));

      opa_in = '0;
      opb_in = '0;
      case (kind0_ff)
         OP_DOT, OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = a0_ff[i];
               opb_in[i] = b0_ff[i];
            end
         end
         OP_CROSS: begin
            opa_in[0] = a0_ff[1]; opb_in[0] = b0_ff[2];
            opa_in[1] = a0_ff[2]; opb_in[1] = b0_ff[1];
            opa_in[2] = a0_ff[2]; opb_in[2] = b0_ff[0];
            opa_in[3] = a0_ff[0]; opb_in[3] = b0_ff[2];
            opa_in[4] = a0_ff[0]; opb_in[4] = b0_ff[1];
            opa_in[5] = a0_ff[1]; opb_in[5] = b0_ff[0];
         end
         OP_MAG, OP_NORM: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = a0_ff[i];
               opb_in[i] = a0_ff[i];
            end
         end
         OP_DIST: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = d1[i];
               opb_in[i] = d1[i];
            end
         end
         default: begin
            opa_in = '0;
            opb_in = '0;
         end
      endcase

      // fold the angle into +-pi/2 and flip the result sign
      aext    = (ZW + 1)'(ang0_ff);
      neg1_in = 1'b0;
      if (aext > HALF_PI_Q16) begin
         aext    = aext - PI_Q16;
         neg1_in = 1'b1;
      end else if (aext < -HALF_PI_Q16) begin
         aext    = aext + PI_Q16;
         neg1_in = 1'b1;
      end
      z1_in = aext[ZW-1:0];
   end

   op_type               kind1_ff;
   vec_type              a1_ff, as1_ff;
   logic [5:0][DW-1:0]   opa1_ff, opb1_ff;
   logic                 f1_ff;
   logic signed [ZW-1:0] z1_ff;
   logic                 neg1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff <= kind0_ff;
         a1_ff    <= a0_ff;
         as1_ff   <= as1_in;
         opa1_ff  <= opa_in;
         opb1_ff  <= opb_in;
         f1_ff    <= f1_in;
         z1_ff    <= z1_in;
         neg1_ff  <= neg1_in;
      end
   end

   // ---------------- stage 2: products ----------------
   op_type               kind2_ff;
   vec_type              as2_ff;
   logic                 f2_ff;
   logic signed [PW-1:0] prod2_ff [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff <= kind1_ff;
         as2_ff   <= as1_ff;
         f2_ff    <= f1_ff;
         for (int i = 0; i < 6; i++) begin
            prod2_ff[i] <= $signed(opa1_ff[i]) * $signed(opb1_ff[i]);
         end
      end
   end

   // ---------------- stage 3: sums and early results ----------------
   logic signed [WW-1:0] w [6];
   sat_type              dot_s;
   sat_type              crs_s [3];
   sat_type              scl_s [3];
   logic [PW-1:0]        sq3_in;
   res_type              er3_in;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         w[i] = WW'(prod2_ff[i]);
      end
      dot_s    = sat_w((w[0] + w[1] + w[2]) >>> FB);
      crs_s[0] = sat_w((w[0] - w[1]) >>> FB);
      crs_s[1] = sat_w((w[2] - w[3]) >>> FB);
      crs_s[2] = sat_w((w[4] - w[5]) >>> FB);
      for (int i = 0; i < 3; i++) begin
         scl_s[i] = sat_w(w[i] >>> FB);
      end
      sq3_in = $unsigned(prod2_ff[0]) + $unsigned(prod2_ff[1]) + $unsigned(prod2_ff[2]);

      er3_in      = '0;
      er3_in.kind = kind2_ff;
      er3_in.st   = ST_OK;
      case (kind2_ff)
         OP_ADD, OP_SUB: begin
            er3_in.rx = $signed(as2_ff[0]);
            er3_in.ry = $signed(as2_ff[1]);
            er3_in.rz = $signed(as2_ff[2]);
            er3_in.st = f2_ff ? ST_SAT : ST_OK;
         end
         OP_DOT: begin
            er3_in.sc = dot_s.val;
            er3_in.st = dot_s.sat ? ST_SAT : ST_OK;
         end
         OP_CROSS: begin
            er3_in.rx = crs_s[0].val;
            er3_in.ry = crs_s[1].val;
            er3_in.rz = crs_s[2].val;
            er3_in.st = (crs_s[0].sat || crs_s[1].sat || crs_s[2].sat) ? ST_SAT : ST_OK;
         end
         OP_SCALE: begin
            er3_in.rx = scl_s[0].val;
            er3_in.ry = scl_s[1].val;
            er3_in.rz = scl_s[2].val;
            er3_in.st = (scl_s[0].sat || scl_s[1].sat || scl_s[2].sat) ? ST_SAT : ST_OK;
         end
         OP_DIST: begin
            // keep the difference overflow until the magnitude arrives
            er3_in.st = f2_ff ? ST_SAT : ST_OK;
         end
         default: begin
            er3_in.st = ST_OK;
         end
      endcase
   end

   res_type       er3_ff;
   logic [PW-1:0] sq3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         er3_ff <= er3_in;
         sq3_ff <= sq3_in;
      end
   end

   // ---------------- rotation branch ----------------
   logic signed [CW-1:0] cos19, sin19;
   vec_type              a19, a35;
   res_type              er20;

   vau_cordic u_cordic (
      .clock   (clock),
      .en      (adv),
      .ang_z   (z1_ff),
      .ang_neg (neg1_ff),
      .cos_out (cos19),
      .sin_out (sin19)
   );

   vau_delay #(.WIDTH($bits(vec_type)), .DEPTH(18)) u_dly_a19 (
      .clock (clock), .en (adv), .din (a1_ff), .dout (a19)
   );

   vau_delay #(.WIDTH($bits(res_type)), .DEPTH(17)) u_dly_er20 (
      .clock (clock), .en (adv), .din (er3_ff), .dout (er20)
   );

   logic signed [RPW-1:0] rp20_ff [6];
   vec_type               a20_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a20_ff <= a19;
         for (int i = 0; i < 3; i++) begin
            rp20_ff[i]     <= cos19 * $signed(a19[i]);
            rp20_ff[i + 3] <= sin19 * $signed(a19[i]);
         end
      end
   end

   // rp20: cx, cy, cz, sx, sy, sz
   sat_type ro0, ro1;
   res_type mid21_in, mid21_ff;

   always_comb begin
      ro0      = '0;
      ro1      = '0;
      mid21_in = er20;
      case (er20.kind)
         OP_ROTX: begin
            ro0 = sat_w((WW'(rp20_ff[1]) - WW'(rp20_ff[5])) >>> FB);
            ro1 = sat_w((WW'(rp20_ff[4]) + WW'(rp20_ff[2])) >>> FB);
            mid21_in.rx = $signed(a20_ff[0]);
            mid21_in.ry = ro0.val;
            mid21_in.rz = ro1.val;
            mid21_in.st = (ro0.sat || ro1.sat) ? ST_SAT : ST_OK;
         end
         OP_ROTY: begin
            ro0 = sat_w((WW'(rp20_ff[0]) + WW'(rp20_ff[5])) >>> FB);
            ro1 = sat_w((WW'(rp20_ff[2]) - WW'(rp20_ff[3])) >>> FB);
            mid21_in.rx = ro0.val;
            mid21_in.ry = $signed(a20_ff[1]);
            mid21_in.rz = ro1.val;
            mid21_in.st = (ro0.sat || ro1.sat) ? ST_SAT : ST_OK;
         end
         OP_ROTZ: begin
            ro0 = sat_w((WW'(rp20_ff[0]) - WW'(rp20_ff[4])) >>> FB);
            ro1 = sat_w((WW'(rp20_ff[3]) + WW'(rp20_ff[1])) >>> FB);
            mid21_in.rx = ro0.val;
            mid21_in.ry = ro1.val;
            mid21_in.rz = $signed(a20_ff[2]);
            mid21_in.st = (ro0.sat || ro1.sat) ? ST_SAT : ST_OK;
         end
         default: begin
            mid21_in = er20;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid21_ff <= mid21_in;
      end
   end

   // ---------------- magnitude and normalize branch ----------------
   logic [MW-1:0]      root35, m52;
   logic signed [QW:0] q52 [3];
   res_type            mid52;

   vau_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .sq_in    (sq3_ff),
      .root_out (root35)
   );

   vau_delay #(.WIDTH($bits(vec_type)), .DEPTH(16)) u_dly_a35 (
      .clock (clock), .en (adv), .din (a19), .dout (a35)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      vau_div u_div (
         .clock   (clock),
         .en      (adv),
         .num_in  ($signed(a35[i])),
         .den_in  (root35),
         .quo_out (q52[i])
      );
   end

   vau_delay #(.WIDTH(MW), .DEPTH(17)) u_dly_m52 (
      .clock (clock), .en (adv), .din (root35), .dout (m52)
   );

   vau_delay #(.WIDTH($bits(res_type)), .DEPTH(31)) u_dly_mid52 (
      .clock (clock), .en (adv), .din (mid21_ff), .dout (mid52)
   );

   // ---------------- final select and output register ----------------
   logic                 msat;
   logic signed [DW-1:0] mval;
   res_type              out_in, out_ff;

   always_comb begin
      msat   = m52[MW-1];
      mval   = msat ? SAT_MAX[DW-1:0] : $signed(m52);
      out_in = mid52;
      case (mid52.kind)
         OP_MAG: begin
            out_in.sc = mval;
            out_in.st = msat ? ST_SAT : ST_OK;
         end
         OP_DIST: begin
            out_in.sc = mval;
            out_in.st = ((mid52.st == ST_SAT) || msat) ? ST_SAT : ST_OK;
         end
         OP_NORM: begin
            if (m52 == '0) begin
               out_in.rx = '0;
               out_in.ry = '0;
               out_in.rz = '0;
               out_in.st = ST_ZERO;
            end else begin
               out_in.rx = DW'(q52[0]);
               out_in.ry = DW'(q52[1]);
               out_in.rz = DW'(q52[2]);
               out_in.st = ST_OK;
            end
         end
         default: begin
            out_in = mid52;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rx     = out_ff.rx;
   assign rsp_ry     = out_ff.ry;
   assign rsp_rz     = out_ff.rz;
   assign rsp_scalar = out_ff.sc;
   assign rsp_status = out_ff.st;

endmodule

`default_nettype wire

// ===== design/vau_checker.sv =====
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit port checker
// Watches the core's ports for stall and response rules; bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector3_arithmetic_unit_core_defines.svh"

module vau_checker import vau_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic signed [DW-1:0] rsp_rx,
   input logic signed [DW-1:0] rsp_ry,
   input logic signed [DW-1:0] rsp_rz,
   input logic signed [DW-1:0] rsp_scalar,
   input logic [1:0]           rsp_status
);

   // hold a stalled response beat
   `VAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rx) && $stable(rsp_ry) && $stable(rsp_rz) && $stable(rsp_scalar) && $stable(rsp_status), "stalled response beat changed")

   `VAU_ASSERT_SAME(a_ready_free, !rsp_valid, req_ready, "request blocked with empty output")

   `VAU_ASSERT_SAME(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready, "request taken while output stalled")

   `VAU_ASSERT_SAME(a_zero_norm, rsp_valid && (rsp_status == ST_ZERO), (rsp_rx == 0) && (rsp_ry == 0) && (rsp_rz == 0) && (rsp_scalar == 0), "zero normalize beat not cleared")

endmodule

bind vector3_arithmetic_unit_core vau_checker u_vau_checker (.*);

`default_nettype wire
